FILE: hw/rtl/dh_shared_secret_modexp_defines.svh
// ----------------------------------------------------------------------------
// dh_shared_secret_modexp_defines
// Assertion macros for the modular exponentiation shared-secret block.
// ----------------------------------------------------------------------------
`ifndef DH_SHARED_SECRET_MODEXP_DEFINES_SVH
`define DH_SHARED_SECRET_MODEXP_DEFINES_SVH

`ifndef SYNTHESIS
`define DHSS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define DHSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define DHSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DHSS_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define DHSS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define DHSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/dhss_pkg.sv
// ----------------------------------------------------------------------------
// dhss_pkg
// Shared types and constants for the shared-secret modexp block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhss_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_P   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR_G = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

FILE: hw/rtl/dhss_modmul.sv
// ----------------------------------------------------------------------------
// dhss_modmul
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle,
// most significant first. Operands must be below m.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhss_modmul #(
    parameter int unsigned W = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_x,
    input  logic [W-1:0]        i_y,
    input  logic [W-1:0]        i_m,
    output dhss_pkg::t_mm_status o_status,
    output logic [W-1:0]        o_res
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [W:0]    dbl;
    logic [W-1:0]  dbl_red;
    logic [W:0]    sum;
    logic [W-1:0]  sum_red;
    logic [W-1:0]  n_acc;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? W'(dbl - {1'b0, i_m}) : W'(dbl);
        sum     = {1'b0, dbl_red} + {1'b0, r_x};
        sum_red = (sum >= {1'b0, i_m}) ? W'(sum - {1'b0, i_m}) : W'(sum);
        n_acc   = r_y[W-1] ? sum_red : dbl_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_y   <= {r_y[W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;
    assign o_res         = r_acc;

endmodule

FILE: hw/rtl/dh_shared_secret_modexp.sv
// ----------------------------------------------------------------------------
// dh_shared_secret_modexp
// Diffie-Hellman public values and shared secret by modular exponentiation.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block reduces g modulo p, then runs
// four square-and-multiply exponentiations (g^a, g^b, B^a, A^b) over all
// MOD_BITS exponent bits, every step on one shared bit-serial modular
// multiplier. A zero modulus skips the reduction and the exponentiations
// and gives all-zero results. Input stall is high from acceptance until
// the result beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dh_shared_secret_modexp_defines.svh"

module dh_shared_secret_modexp #(
    parameter int unsigned MOD_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dhss_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [MOD_BITS-1:0]           i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [MOD_BITS-1:0]           i_private_a,
    input  logic [MOD_BITS-1:0]           i_private_b,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [MOD_BITS-1:0]           o_public_a,
    output logic [MOD_BITS-1:0]           o_public_b,
    output logic [MOD_BITS-1:0]           o_shared_secret,
    output logic                          o_secrets_match
);

    localparam int unsigned W  = MOD_BITS;
    localparam int unsigned IW = $clog2(W);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_SQ   = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [W-1:0]  r_mod, r_gen;
    logic [W-1:0]  r_a, n_a, r_b, n_b;
    logic [W-1:0]  r_g_red, n_g_red;
    logic [W-1:0]  r_pa, n_pa, r_pb, n_pb, r_sa, n_sa, r_sb, n_sb;
    logic [W-1:0]  r_mx, n_mx, r_my, n_my;
    logic          r_start, n_start;
    logic [1:0]    r_k, n_k;
    logic [IW-1:0] r_idx, n_idx;

    dhss_pkg::t_mm_status mm_st;
    logic [W-1:0]  mm_res;
    logic [W-1:0]  one_m;
    logic [W-1:0]  exp_sel;
    logic [W-1:0]  base_sel;
    logic          exp_bit;
    logic          adv;
    logic          match;
    logic          in_work;
    logic          pub_ok;

    dhss_modmul #(.W(W)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_x      (r_mx),
        .i_y      (r_my),
        .i_m      (r_mod),
        .o_status (mm_st),
        .o_res    (mm_res)
    );

    // 1 mod p
    assign one_m   = {{(W-1){1'b0}}, (r_mod != W'(1))};
    assign exp_sel = r_k[0] ? r_b : r_a;
    assign exp_bit = exp_sel[r_idx];

    always_comb begin
        case (r_k)
            2'd2:    base_sel = r_pb;
            2'd3:    base_sel = r_pa;
            default: base_sel = r_g_red;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_g_red = r_g_red;
        n_pa    = r_pa;
        n_pb    = r_pb;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_mx    = r_mx;
        n_my    = r_my;
        n_start = 1'b0;
        n_k     = r_k;
        n_idx   = r_idx;
        adv     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a = i_private_a;
                    n_b = i_private_b;
                    if (r_mod == '0) begin
                        n_pa    = '0;
                        n_pb    = '0;
                        n_sa    = '0;
                        n_sb    = '0;
                        n_state = S_OUT;
                    end else begin
                        n_mx    = one_m;
                        n_my    = r_gen;
                        n_start = 1'b1;
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_st.done) begin
                    n_g_red = mm_res;
                    n_k     = '0;
                    n_idx   = IW'(W - 1);
                    n_mx    = one_m;
                    n_my    = one_m;
                    n_start = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (mm_st.done) begin
                    if (exp_bit) begin
                        n_mx    = mm_res;
                        n_my    = base_sel;
                        n_start = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            S_MUL: begin
                adv = mm_st.done;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // next exponent bit, or close this exponentiation
        if (adv) begin
            if (r_idx == '0) begin
                case (r_k)
                    2'd0:    n_pa = mm_res;
                    2'd1:    n_pb = mm_res;
                    2'd2:    n_sa = mm_res;
                    default: n_sb = mm_res;
                endcase
                if (r_k == 2'd3) begin
                    n_state = S_OUT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_idx   = IW'(W - 1);
                    n_mx    = one_m;
                    n_my    = one_m;
                    n_start = 1'b1;
                    n_state = S_SQ;
                end
            end else begin
                n_idx   = r_idx - 1'b1;
                n_mx    = mm_res;
                n_my    = mm_res;
                n_start = 1'b1;
                n_state = S_SQ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_mod   <= W'(2);
            r_gen   <= W'(1);
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    dhss_pkg::CFG_MODULUS_P:   r_mod <= i_cfg_wdata;
                    dhss_pkg::CFG_GENERATOR_G: r_gen <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_g_red <= n_g_red;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_k     <= n_k;
        r_idx   <= n_idx;
    end

    assign match           = (r_sa == r_sb);
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_public_a      = r_pa;
    assign o_public_b      = r_pb;
    assign o_shared_secret = match ? r_sa : '0;
    assign o_secrets_match = match;

    assign in_work = (r_state == S_RED) || (r_state == S_SQ) || (r_state == S_MUL);
    assign pub_ok  = (r_mod == '0) || ((r_pa < r_mod) && (r_pb < r_mod));

    `DHSS_ASSERT_IMPL(a_start_idle_unit, i_clk, i_rst_n, r_start, !mm_st.busy, "start while busy")
    `DHSS_ASSERT_IMPL(a_busy_in_work, i_clk, i_rst_n, mm_st.busy, in_work, "busy outside work")
    `DHSS_ASSERT_IMPL(a_result_reduced, i_clk, i_rst_n, o_out_valid, pub_ok, "not reduced")
    `DHSS_ASSERT_NEXT(a_done_taken, i_clk, i_rst_n, mm_st.done, r_start || o_out_valid, "done lost")

endmodule
